@@ design/cra_pkg.sv @@
// ----------------------------------------------------------------------------
// cra_pkg: shared types and constants
// Opcode codes, architectural state record and ALU result record for the
// register/ALU execute unit.
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int OP_W   = 6;
    localparam int BYTE_W = 8;

    typedef logic [OP_W-1:0]   t_opcode;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_opcode OP_ADC = 6'd0;
    localparam t_opcode OP_SBC = 6'd1;
    localparam t_opcode OP_CMP = 6'd2;
    localparam t_opcode OP_CPX = 6'd3;
    localparam t_opcode OP_CPY = 6'd4;
    localparam t_opcode OP_AND = 6'd5;
    localparam t_opcode OP_ORA = 6'd6;
    localparam t_opcode OP_EOR = 6'd7;
    localparam t_opcode OP_ASL = 6'd8;
    localparam t_opcode OP_LSR = 6'd9;
    localparam t_opcode OP_ROL = 6'd10;
    localparam t_opcode OP_ROR = 6'd11;
    localparam t_opcode OP_INC = 6'd12;
    localparam t_opcode OP_DEC = 6'd13;
    localparam t_opcode OP_INX = 6'd14;
    localparam t_opcode OP_INY = 6'd15;
    localparam t_opcode OP_DEX = 6'd16;
    localparam t_opcode OP_DEY = 6'd17;
    localparam t_opcode OP_BIT = 6'd18;
    localparam t_opcode OP_CLC = 6'd19;
    localparam t_opcode OP_SEC = 6'd20;
    localparam t_opcode OP_CLD = 6'd21;
    localparam t_opcode OP_SED = 6'd22;
    localparam t_opcode OP_CLI = 6'd23;
    localparam t_opcode OP_SEI = 6'd24;
    localparam t_opcode OP_CLV = 6'd25;
    localparam t_opcode OP_LDA = 6'd26;
    localparam t_opcode OP_LDX = 6'd27;
    localparam t_opcode OP_LDY = 6'd28;
    localparam t_opcode OP_STA = 6'd29;
    localparam t_opcode OP_STX = 6'd30;
    localparam t_opcode OP_STY = 6'd31;
    localparam t_opcode OP_STZ = 6'd32;
    localparam t_opcode OP_TAX = 6'd33;
    localparam t_opcode OP_TAY = 6'd34;
    localparam t_opcode OP_TXA = 6'd35;
    localparam t_opcode OP_TYA = 6'd36;
    localparam t_opcode OP_TSX = 6'd37;
    localparam t_opcode OP_TXS = 6'd38;
    localparam t_opcode OP_TRB = 6'd39;
    localparam t_opcode OP_TSB = 6'd40;
    localparam t_opcode OP_NOP = 6'd41;
    localparam t_opcode OP_PLP = 6'd42;  // load status from operand
    localparam t_opcode OP_PHP = 6'd43;  // read status

    localparam t_byte SP_RESET = 8'hFD;

    typedef struct packed {
        t_byte acc;
        t_byte xr;
        t_byte yr;
        t_byte sp;
        logic  n;
        logic  v;
        logic  d;
        logic  i;
        logic  z;
        logic  c;
    } t_arch_state;

    typedef struct packed {
        t_byte       result;
        logic        mem_write;
        t_arch_state st;
    } t_alu_res;

    // N V 1 B D I Z C; bits 5 and 4 always read as one
    function automatic t_byte status_byte(input t_arch_state s);
        status_byte = {s.n, s.v, 2'b11, s.d, s.i, s.z, s.c};
    endfunction

endpackage

@@ design/cra_intf.sv @@
// ----------------------------------------------------------------------------
// cra_in_if / cra_out_if: valid/ready channels
// Operation channel into the execute unit and result channel out of it.
// ----------------------------------------------------------------------------
interface cra_in_if;
    logic       valid;
    logic       ready;
    logic [5:0] opcode;
    logic [7:0] operand;
    logic       to_accumulator;

    modport source (output valid, output opcode, output operand,
                    output to_accumulator, input ready);
    modport sink   (input valid, input opcode, input operand,
                    input to_accumulator, output ready);
endinterface

interface cra_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result;
    logic       mem_write;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] status_out;

    modport source (output valid, output result, output mem_write,
                    output acc_out, output x_out, output y_out,
                    output status_out, input ready);
    modport sink   (input valid, input result, input mem_write,
                    input acc_out, input x_out, input y_out,
                    input status_out, output ready);
endinterface

@@ design/cra_alu.sv @@
// ----------------------------------------------------------------------------
// cra_alu: single-pass execute logic
// Computes the next architectural state, the memory write byte and its
// strobe for one operation from the current state.
// ----------------------------------------------------------------------------
module cra_alu
    import cra_pkg::*;
(
    input  t_opcode     i_op,
    input  t_byte       i_operand,
    input  logic        i_to_acc,
    input  t_arch_state i_st,
    output t_alu_res    o_res
);

    t_byte       m;
    t_byte       src;
    t_byte       rmw_v;
    logic        rmw;
    logic        rmw_c;
    logic [8:0]  bin_sum;
    logic [5:0]  dec_lo;
    logic [9:0]  dec_t;
    logic [9:0]  dec_t_adj;
    logic [8:0]  sub_d;
    logic [4:0]  sub_lo;
    logic [4:0]  sub_lo_adj;
    logic [8:0]  sub_hi;
    logic [8:0]  sub_hi_adj;
    t_byte       dec_diff;
    logic [8:0]  cmp_d;
    t_byte       cmp_reg;
    t_arch_state s;
    t_byte       res;
    logic        wr;

    assign m   = i_operand;
    assign src = i_to_acc ? i_st.acc : i_operand;

    // binary add
    assign bin_sum = {1'b0, i_st.acc} + {1'b0, m} + {8'd0, i_st.c};

    // decimal add: low digit fix-up, then high digit
    always_comb begin
        dec_lo = {2'b00, i_st.acc[3:0]} + {2'b00, m[3:0]} + {5'd0, i_st.c};
        if (dec_lo > 6'd9) begin
            dec_lo = dec_lo + 6'd6;
        end
        dec_t = {2'b00, i_st.acc[7:4], 4'h0} + {2'b00, m[7:4], 4'h0}
              + {6'd0, dec_lo[3:0]} + (dec_lo > 6'd15 ? 10'h010 : 10'h000);
        dec_t_adj = (dec_t >= 10'h0A0) ? dec_t + 10'h060 : dec_t;
    end

    // subtract: binary difference, then digit-wise borrow fix-ups
    always_comb begin
        sub_d = {1'b0, i_st.acc} - {1'b0, m} - {8'd0, ~i_st.c};
        sub_lo = {1'b0, i_st.acc[3:0]} - {1'b0, m[3:0]} - {4'd0, ~i_st.c};
        sub_lo_adj = sub_lo[4] ? sub_lo - 5'd6 : sub_lo;
        sub_hi = {1'b0, i_st.acc[7:4], 4'h0} - {1'b0, m[7:4], 4'h0}
               - {4'd0, sub_lo_adj[4], 4'h0};
        sub_hi_adj = sub_hi[8] ? sub_hi - 9'h060 : sub_hi;
        dec_diff = {sub_hi_adj[7:4], sub_lo_adj[3:0]};
    end

    // compares
    always_comb begin
        case (i_op)
            OP_CPX:  cmp_reg = i_st.xr;
            OP_CPY:  cmp_reg = i_st.yr;
            default: cmp_reg = i_st.acc;
        endcase
        cmp_d = {1'b0, cmp_reg} - {1'b0, m};
    end

    // shifts, rotates, inc and dec on A or the operand
    always_comb begin
        rmw   = 1'b1;
        rmw_c = i_st.c;
        case (i_op)
            OP_ASL: begin
                rmw_v = {src[6:0], 1'b0};
                rmw_c = src[7];
            end
            OP_LSR: begin
                rmw_v = {1'b0, src[7:1]};
                rmw_c = src[0];
            end
            OP_ROL: begin
                rmw_v = {src[6:0], i_st.c};
                rmw_c = src[7];
            end
            OP_ROR: begin
                rmw_v = {i_st.c, src[7:1]};
                rmw_c = src[0];
            end
            OP_INC:  rmw_v = src + 8'd1;
            OP_DEC:  rmw_v = src - 8'd1;
            default: begin
                rmw_v = src;
                rmw   = 1'b0;
            end
        endcase
    end

    always_comb begin
        s   = i_st;
        res = 8'd0;
        wr  = 1'b0;
        case (i_op)
            OP_ADC: begin
                if (i_st.d) begin
                    s.z   = (bin_sum[7:0] == 8'd0);
                    s.n   = dec_t[7];
                    s.v   = (i_st.acc[7] ^ dec_t[7]) & ~(i_st.acc[7] ^ m[7]);
                    s.c   = (dec_t_adj > 10'h0FF);
                    s.acc = dec_t_adj[7:0];
                end else begin
                    s.c   = bin_sum[8];
                    s.v   = (i_st.acc[7] ^ bin_sum[7]) & (m[7] ^ bin_sum[7]);
                    s.acc = bin_sum[7:0];
                    s.z   = (bin_sum[7:0] == 8'd0);
                    s.n   = bin_sum[7];
                end
            end
            OP_SBC: begin
                s.v   = (i_st.acc[7] ^ m[7]) & (i_st.acc[7] ^ sub_d[7]);
                s.c   = ~sub_d[8];
                s.acc = i_st.d ? dec_diff : sub_d[7:0];
                s.z   = (s.acc == 8'd0);
                s.n   = s.acc[7];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                s.c = ~cmp_d[8];
                s.z = (cmp_d[7:0] == 8'd0);
                s.n = cmp_d[7];
            end
            OP_AND: s.acc = i_st.acc & m;
            OP_ORA: s.acc = i_st.acc | m;
            OP_EOR: s.acc = i_st.acc ^ m;
            OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
                s.c = rmw_c;
                s.z = (rmw_v == 8'd0);
                s.n = rmw_v[7];
                if (i_to_acc) begin
                    s.acc = rmw_v;
                end else begin
                    res = rmw_v;
                    wr  = rmw;
                end
            end
            OP_INX: s.xr = i_st.xr + 8'd1;
            OP_INY: s.yr = i_st.yr + 8'd1;
            OP_DEX: s.xr = i_st.xr - 8'd1;
            OP_DEY: s.yr = i_st.yr - 8'd1;
            OP_BIT: begin
                s.v = m[6];
                s.n = m[7];
                s.z = ((m & i_st.acc) == 8'd0);
            end
            OP_CLC: s.c = 1'b0;
            OP_SEC: s.c = 1'b1;
            OP_CLD: s.d = 1'b0;
            OP_SED: s.d = 1'b1;
            OP_CLI: s.i = 1'b0;
            OP_SEI: s.i = 1'b1;
            OP_CLV: s.v = 1'b0;
            OP_LDA: s.acc = m;
            OP_LDX: s.xr  = m;
            OP_LDY: s.yr  = m;
            OP_STA: begin
                res = i_st.acc;
                wr  = 1'b1;
            end
            OP_STX: begin
                res = i_st.xr;
                wr  = 1'b1;
            end
            OP_STY: begin
                res = i_st.yr;
                wr  = 1'b1;
            end
            OP_STZ: wr = 1'b1;
            OP_TAX: s.xr  = i_st.acc;
            OP_TAY: s.yr  = i_st.acc;
            OP_TXA: s.acc = i_st.xr;
            OP_TYA: s.acc = i_st.yr;
            OP_TSX: s.xr  = i_st.sp;
            OP_TXS: s.sp  = i_st.xr;
            OP_TRB: begin
                s.z = ((m & i_st.acc) == 8'd0);
                res = m & ~i_st.acc;
                wr  = 1'b1;
            end
            OP_TSB: begin
                s.z = ((m & i_st.acc) == 8'd0);
                res = m | i_st.acc;
                wr  = 1'b1;
            end
            OP_PLP: begin
                s.n = m[7];
                s.v = m[6];
                s.d = m[3];
                s.i = m[2];
                s.z = m[1];
                s.c = m[0];
            end
            OP_PHP: res = status_byte(i_st);
            default: ;  // NOP and undefined codes
        endcase

        // N and Z follow the written register: loads, logic, transfers but TXS, X/Y inc/dec
        case (i_op)
            OP_AND, OP_ORA, OP_EOR, OP_LDA, OP_TXA, OP_TYA: begin
                s.z = (s.acc == 8'd0);
                s.n = s.acc[7];
            end
            OP_INX, OP_DEX, OP_LDX, OP_TAX, OP_TSX: begin
                s.z = (s.xr == 8'd0);
                s.n = s.xr[7];
            end
            OP_INY, OP_DEY, OP_LDY, OP_TAY: begin
                s.z = (s.yr == 8'd0);
                s.n = s.yr[7];
            end
            default: ;
        endcase
    end

    assign o_res.result    = res;
    assign o_res.mem_write = wr;
    assign o_res.st        = s;

endmodule

@@ design/cpu_register_alu_execute.sv @@
// ----------------------------------------------------------------------------
// cpu_register_alu_execute: 65C02-style register and ALU execute unit
// Holds A, X, Y, SP and the N V D I Z C flags; runs one operation per
// transfer and reports the memory write byte and the updated registers.
// ----------------------------------------------------------------------------
// Pipeline: an accepted operation passes the input register, then the execute
//   logic into the result register. Throughput: one operation per cycle
//   while the result side is not stalled; the state feedback is a single
//   register stage, so consecutive operations see each other's results.
// Reset (synchronous, active low): A, X, Y, flags cleared, SP = 0xFD,
//   I flag set, both pipeline stages emptied.
// ----------------------------------------------------------------------------
module cpu_register_alu_execute
    import cra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cra_in_if.sink     i_req,
    cra_out_if.source  o_rsp
);

    // Input stage: holds one accepted operation
    logic        r_in_valid;
    t_opcode     r_in_op;
    t_byte       r_in_operand;
    logic        r_in_to_acc;

    // Result stage
    logic        r_out_valid;
    t_byte       r_result;
    logic        r_mem_write;
    t_byte       r_acc_out;
    t_byte       r_x_out;
    t_byte       r_y_out;
    t_byte       r_status_out;

    // Architectural state
    t_arch_state r_st;

    t_alu_res    n_res;
    logic        in_xfer;
    logic        advance;

    // An operation executes when the result register is free or drains now.
    assign advance = r_in_valid && (!r_out_valid || o_rsp.ready);
    // Input register refills in the same cycle it hands its op on.
    assign i_req.ready = !r_in_valid || advance;
    assign in_xfer = i_req.valid && i_req.ready;

    cra_alu u_alu (
        .i_op      (r_in_op),
        .i_operand (r_in_operand),
        .i_to_acc  (r_in_to_acc),
        .i_st      (r_st),
        .o_res     (n_res)
    );

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '{acc: 8'd0, xr: 8'd0, yr: 8'd0, sp: SP_RESET,
                             n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1,
                             z: 1'b0, c: 1'b0};
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_st        <= n_res.st;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_op      <= i_req.opcode;
            r_in_operand <= i_req.operand;
            r_in_to_acc  <= i_req.to_accumulator;
        end
        if (advance) begin
            r_result     <= n_res.result;
            r_mem_write  <= n_res.mem_write;
            r_acc_out    <= n_res.st.acc;
            r_x_out      <= n_res.st.xr;
            r_y_out      <= n_res.st.yr;
            r_status_out <= status_byte(n_res.st);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.result     = r_result;
    assign o_rsp.mem_write  = r_mem_write;
    assign o_rsp.acc_out    = r_acc_out;
    assign o_rsp.x_out      = r_x_out;
    assign o_rsp.y_out      = r_y_out;
    assign o_rsp.status_out = r_status_out;

    // A held op is never dropped while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input stage lost an operation");

    // An empty input stage always takes a transfer.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_req.ready)
        else $error("input stage empty but not ready");

    // State moves only when an operation executes.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_st))
        else $error("architectural state changed without an operation");

    // Only TXS writes the stack pointer.
    a_sp_txs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_op != OP_TXS)) |=> $stable(r_st.sp))
        else $error("stack pointer changed by an op other than TXS");

    // Reported status always carries the fixed ones in bits 5 and 4.
    a_status_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status_out[5:4] == 2'b11))
        else $error("status bits 5:4 not set");

endmodule

@@ dv/cpu_register_alu_execute_test.sv @@
// ----------------------------------------------------------------------------
// cpu_register_alu_execute_test: self-checking bench for the execute unit
// Short directed checks first: reset state, binary and BCD arithmetic, status
// load and read, BIT/TRB/TSB, compares, shifts on A and on memory. Then a long
// random run with back-pressure on both channels. A bench-side model of A, X,
// Y, SP and the flags predicts every result, and each result is checked field
// by field in transfer order.
// ----------------------------------------------------------------------------
module cpu_register_alu_execute_test;
    import cra_pkg::*;

    localparam int      RANDOM_ITEMS   = 1850;
    localparam int      PRESSURE_ITEMS = 40;
    localparam int      HOLD_CYCLES    = 80;    // long receiver hold-off
    localparam int      IDLE_PCT       = 31;    // idle rate for both sides
    localparam int      WATCHDOG_LIMIT = 5000;  // cycles without any transfer
    localparam int      DRAIN_CYCLES   = 8;     // extra wait after the last result
    localparam t_opcode LAST_UNDEF_OP  = 6'd63; // 44..63 behave as NOP

    // Operand values that sit on carry, sign and BCD boundaries
    localparam t_byte CORNER_BYTES [6] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h99, 8'h01};

    // One expected result transfer
    typedef struct {
        t_byte result;
        logic  mem_write;
        t_byte acc;
        t_byte xr;
        t_byte yr;
        t_byte status;
    } t_exec_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cra_in_if  u_in ();
    cra_out_if u_out ();

    cpu_register_alu_execute u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_in),
        .o_rsp   (u_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bench copy of the architectural state, advanced at each input transfer
    t_arch_state   cpu_state;
    t_exec_outcome pending_outcomes[$];
    int            error_count = 0;

    // Control shared with the receiver: calm_mode turns idling off on both
    // sides; bumping hold_ticket asks the receiver for one long hold-off.
    logic calm_mode   = 1'b0;
    int   hold_ticket = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic t_byte packed_status();
        return {cpu_state.n, cpu_state.v, 2'b11, cpu_state.d, cpu_state.i,
                cpu_state.z, cpu_state.c};
    endfunction

    function automatic void flag_nz(input t_byte val);
        cpu_state.z = (val == 8'h00);
        cpu_state.n = val[7];
    endfunction

    // C means no borrow; N and Z come from the 8-bit difference
    function automatic void compare_reg(input t_byte r, input t_byte m);
        int diff;
        diff        = (int'(r) - int'(m)) & 'h1FF;
        cpu_state.c = (diff & 'h100) == 0;
        flag_nz(t_byte'(diff));
    endfunction

    task automatic execute_op(input t_opcode op, input t_byte m, input logic to_a);
        t_exec_outcome outc;
        t_byte         src;
        t_byte         shifted;
        logic          rmw;
        int            a, mi, cin, sum, lo, hi, tmp, borrow, diff;
        a             = cpu_state.acc;
        mi            = m;
        cin           = cpu_state.c;
        src           = to_a ? cpu_state.acc : m;
        rmw           = 1'b0;
        shifted       = '0;
        outc.result    = '0;
        outc.mem_write = 1'b0;
        case (op)
            OP_ADC: begin
                if (cpu_state.d) begin
                    // BCD add: Z from the plain binary sum, N/V taken before
                    // the high-digit fix-up, C after it
                    lo          = (a & 'h0F) + (mi & 'h0F) + cin;
                    cpu_state.z = ((a + mi + cin) & 'hFF) == 0;
                    if (lo > 'h09) lo = lo + 6;
                    tmp = (a & 'hF0) + (mi & 'hF0) + (lo & 'h0F) + ((lo > 'h0F) ? 'h10 : 0);
                    cpu_state.n = tmp[7];
                    cpu_state.v = (((a ^ tmp) & ~(a ^ mi)) & 'h80) != 0;
                    if (tmp >= 'hA0) tmp = tmp + 'h60;
                    cpu_state.c   = tmp > 'hFF;
                    cpu_state.acc = t_byte'(tmp);
                end else begin
                    sum           = a + mi + cin;
                    cpu_state.c   = sum > 'hFF;
                    cpu_state.v   = (((a ^ sum) & (mi ^ sum)) & 'h80) != 0;
                    cpu_state.acc = t_byte'(sum);
                    flag_nz(cpu_state.acc);
                end
            end
            OP_SBC: begin
                // V and C always from the binary difference
                borrow      = cpu_state.c ? 0 : 1;
                diff        = (a - mi - borrow) & 'h1FF;
                cpu_state.v = (((a ^ mi) & (a ^ diff)) & 'h80) != 0;
                cpu_state.c = (diff & 'h100) == 0;
                if (cpu_state.d) begin
                    lo = ((a & 'h0F) - (mi & 'h0F) - borrow) & 'hFFFF;
                    if ((lo & 'h10) != 0) lo = (lo - 6) & 'hFFFF;
                    hi = ((a & 'hF0) - (mi & 'hF0) - (lo & 'h10)) & 'hFFFF;
                    if ((hi & 'h100) != 0) hi = (hi - 'h60) & 'hFFFF;
                    cpu_state.acc = t_byte'((lo & 'h0F) | (hi & 'hF0));
                end else begin
                    cpu_state.acc = t_byte'(diff);
                end
                flag_nz(cpu_state.acc);
            end
            OP_CMP: compare_reg(cpu_state.acc, m);
            OP_CPX: compare_reg(cpu_state.xr, m);
            OP_CPY: compare_reg(cpu_state.yr, m);
            OP_AND: begin cpu_state.acc = cpu_state.acc & m; flag_nz(cpu_state.acc); end
            OP_ORA: begin cpu_state.acc = cpu_state.acc | m; flag_nz(cpu_state.acc); end
            OP_EOR: begin cpu_state.acc = cpu_state.acc ^ m; flag_nz(cpu_state.acc); end
            OP_ASL: begin
                cpu_state.c = src[7];
                shifted     = {src[6:0], 1'b0};
                rmw         = 1'b1;
            end
            OP_LSR: begin
                cpu_state.c = src[0];
                shifted     = {1'b0, src[7:1]};
                rmw         = 1'b1;
            end
            OP_ROL: begin
                shifted     = {src[6:0], cpu_state.c};
                cpu_state.c = src[7];
                rmw         = 1'b1;
            end
            OP_ROR: begin
                shifted     = {cpu_state.c, src[7:1]};
                cpu_state.c = src[0];
                rmw         = 1'b1;
            end
            OP_INC: begin shifted = src + 8'd1; rmw = 1'b1; end
            OP_DEC: begin shifted = src - 8'd1; rmw = 1'b1; end
            OP_INX: begin cpu_state.xr = cpu_state.xr + 8'd1; flag_nz(cpu_state.xr); end
            OP_INY: begin cpu_state.yr = cpu_state.yr + 8'd1; flag_nz(cpu_state.yr); end
            OP_DEX: begin cpu_state.xr = cpu_state.xr - 8'd1; flag_nz(cpu_state.xr); end
            OP_DEY: begin cpu_state.yr = cpu_state.yr - 8'd1; flag_nz(cpu_state.yr); end
            OP_BIT: begin
                cpu_state.v = m[6];
                cpu_state.n = m[7];
                cpu_state.z = (m & cpu_state.acc) == 8'h00;
            end
            OP_CLC: cpu_state.c = 1'b0;
            OP_SEC: cpu_state.c = 1'b1;
            OP_CLD: cpu_state.d = 1'b0;
            OP_SED: cpu_state.d = 1'b1;
            OP_CLI: cpu_state.i = 1'b0;
            OP_SEI: cpu_state.i = 1'b1;
            OP_CLV: cpu_state.v = 1'b0;
            OP_LDA: begin cpu_state.acc = m; flag_nz(m); end
            OP_LDX: begin cpu_state.xr  = m; flag_nz(m); end
            OP_LDY: begin cpu_state.yr  = m; flag_nz(m); end
            OP_STA: begin outc.result = cpu_state.acc; outc.mem_write = 1'b1; end
            OP_STX: begin outc.result = cpu_state.xr;  outc.mem_write = 1'b1; end
            OP_STY: begin outc.result = cpu_state.yr;  outc.mem_write = 1'b1; end
            OP_STZ: begin outc.result = 8'h00;         outc.mem_write = 1'b1; end
            OP_TAX: begin cpu_state.xr  = cpu_state.acc; flag_nz(cpu_state.xr);  end
            OP_TAY: begin cpu_state.yr  = cpu_state.acc; flag_nz(cpu_state.yr);  end
            OP_TXA: begin cpu_state.acc = cpu_state.xr;  flag_nz(cpu_state.acc); end
            OP_TYA: begin cpu_state.acc = cpu_state.yr;  flag_nz(cpu_state.acc); end
            OP_TSX: begin cpu_state.xr  = cpu_state.sp;  flag_nz(cpu_state.xr);  end
            OP_TXS: cpu_state.sp = cpu_state.xr;     // no flags touched
            OP_TRB: begin
                cpu_state.z    = (m & cpu_state.acc) == 8'h00;
                outc.result    = m & ~cpu_state.acc;
                outc.mem_write = 1'b1;
            end
            OP_TSB: begin
                cpu_state.z    = (m & cpu_state.acc) == 8'h00;
                outc.result    = m | cpu_state.acc;
                outc.mem_write = 1'b1;
            end
            OP_PLP: begin
                // bits 5 and 4 of the operand are dropped
                cpu_state.n = m[7];
                cpu_state.v = m[6];
                cpu_state.d = m[3];
                cpu_state.i = m[2];
                cpu_state.z = m[1];
                cpu_state.c = m[0];
            end
            OP_PHP: outc.result = packed_status();  // no memory write flagged
            default: ;                              // NOP and undefined codes
        endcase
        // read-modify-write ops land in A or go back to memory
        if (rmw) begin
            flag_nz(shifted);
            if (to_a) begin
                cpu_state.acc = shifted;
            end else begin
                outc.result    = shifted;
                outc.mem_write = 1'b1;
            end
        end
        outc.acc    = cpu_state.acc;
        outc.xr     = cpu_state.xr;
        outc.yr     = cpu_state.yr;
        outc.status = packed_status();
        pending_outcomes.push_back(outc);
    endtask

    // ------------------------------------------------------------------------
    // Sender: one operation per call. valid stays high between back-to-back
    // transfers and drops only on an idle gap or at the very end.
    // ------------------------------------------------------------------------
    task automatic send_op(input t_opcode op, input t_byte opnd, input logic to_a);
        // each idle cycle is drawn on its own, so about IDLE_PCT of cycles idle
        while (!calm_mode && $urandom_range(99) < IDLE_PCT) begin
            u_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in.valid          <= 1'b1;
        u_in.opcode         <= op;
        u_in.operand        <= opnd;
        u_in.to_accumulator <= to_a;
        do @(posedge i_clk); while (!u_in.ready);
        execute_op(op, opnd, to_a);
    endtask

    function automatic t_opcode pick_opcode();
        if ($urandom_range(99) < 8)
            return t_opcode'($urandom_range(OP_PHP + 1, LAST_UNDEF_OP));
        return t_opcode'($urandom_range(OP_PHP));
    endfunction

    function automatic t_byte pick_operand();
        case ($urandom_range(3))
            0:       return CORNER_BYTES[$urandom_range(5)];
            1:       return {4'($urandom_range(9)), 4'($urandom_range(9))};  // valid BCD
            default: return t_byte'($urandom);
        endcase
    endfunction

    function automatic t_byte pick_bcd();
        return {4'($urandom_range(9)), 4'($urandom_range(9))};
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and checker: ready drops at random, or for one long stretch
    // on request. Each result transfer is matched against the oldest
    // prediction.
    // ------------------------------------------------------------------------
    int hold_served = 0;
    int hold_left   = 0;

    always @(posedge i_clk) begin
        t_exec_outcome want;
        if (i_rst_n && u_out.valid && u_out.ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with no prediction pending");
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (u_out.result !== want.result) begin
                    $error("result: expected %h, got %h", want.result, u_out.result);
                    error_count++;
                end
                if (u_out.mem_write !== want.mem_write) begin
                    $error("mem_write: expected %b, got %b", want.mem_write, u_out.mem_write);
                    error_count++;
                end
                if (u_out.acc_out !== want.acc) begin
                    $error("acc_out: expected %h, got %h", want.acc, u_out.acc_out);
                    error_count++;
                end
                if (u_out.x_out !== want.xr) begin
                    $error("x_out: expected %h, got %h", want.xr, u_out.x_out);
                    error_count++;
                end
                if (u_out.y_out !== want.yr) begin
                    $error("y_out: expected %h, got %h", want.yr, u_out.y_out);
                    error_count++;
                end
                if (u_out.status_out !== want.status) begin
                    $error("status_out: expected %h, got %h", want.status, u_out.status_out);
                    error_count++;
                end
            end
        end
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            u_out.ready <= 1'b0;
        end else begin
            u_out.ready <= calm_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: any transfer on either channel restarts the count
    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("cpu_register_alu_execute verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Status right after reset: I set, bits 5/4 forced; NOP with the A flag
    // set leaves everything alone
    task automatic test_reset_state();
        send_op(OP_PHP, 8'h00, 1'b0);
        send_op(OP_NOP, 8'hFF, 1'b1);
    endtask

    // Signed overflow into 0x80, carry out of 0xFF, borrow through 0x80
    task automatic test_binary_arith();
        send_op(OP_LDA, 8'h7F, 1'b0);
        send_op(OP_CLC, 8'h00, 1'b0);
        send_op(OP_ADC, 8'h01, 1'b0);
        send_op(OP_ADC, 8'hFF, 1'b0);
        send_op(OP_SEC, 8'h00, 1'b0);
        send_op(OP_SBC, 8'h80, 1'b0);
    endtask

    // BCD carry out of 99, borrow with low-digit fix-up, non-BCD digits
    task automatic test_decimal_arith();
        send_op(OP_SED, 8'h00, 1'b0);
        send_op(OP_LDA, 8'h99, 1'b0);
        send_op(OP_ADC, 8'h01, 1'b0);
        send_op(OP_SBC, 8'h0F, 1'b0);
        send_op(OP_ADC, 8'hFF, 1'b0);
        send_op(OP_CLD, 8'h00, 1'b0);
    endtask

    // Load status ignores bits 5/4; read status returns them as ones
    task automatic test_status_load();
        send_op(OP_PLP, 8'hFF, 1'b0);
        send_op(OP_PHP, 8'h00, 1'b0);
        send_op(OP_PLP, 8'h00, 1'b0);
    endtask

    // BIT takes N/V from the operand; TRB/TSB write back and set Z from A&M
    task automatic test_bit_ops();
        send_op(OP_BIT, 8'hC0, 1'b0);
        send_op(OP_TRB, 8'hFF, 1'b0);
        send_op(OP_TSB, 8'h00, 1'b0);
    endtask

    // Equal compare, then shifts on A and on memory and a decrement on memory
    task automatic test_compare_shift();
        send_op(OP_CPX, 8'h00, 1'b0);
        send_op(OP_ASL, 8'h55, 1'b1);
        send_op(OP_ROR, 8'hFF, 1'b0);
        send_op(OP_DEC, 8'h00, 1'b0);
    endtask

    // Mostly single random ops; some short BCD add/subtract sequences so
    // decimal mode sees valid digits often. One stretch runs with no idling.
    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm_mode = (sent >= 600 && sent < 900);
            if ($urandom_range(99) < 15) begin
                send_op(OP_SED, 8'h00, 1'b0);
                send_op(OP_LDA, pick_bcd(), 1'b0);
                send_op($urandom_range(1) ? OP_SEC : OP_CLC, 8'h00, 1'b0);
                send_op($urandom_range(1) ? OP_ADC : OP_SBC, pick_bcd(), 1'b0);
                sent += 4;
            end else begin
                send_op(pick_opcode(), pick_operand(), 1'($urandom_range(1)));
                sent++;
            end
        end
        calm_mode = 1'b0;
    endtask

    // Receiver holds off for a long stretch while the sender keeps going,
    // so the pipeline fills and input ready drops.
    task automatic test_backpressure();
        hold_ticket++;
        repeat (PRESSURE_ITEMS)
            send_op(pick_opcode(), pick_operand(), 1'($urandom_range(1)));
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        u_in.valid          <= 1'b0;
        u_in.opcode         <= OP_NOP;
        u_in.operand        <= 8'h00;
        u_in.to_accumulator <= 1'b0;

        cpu_state     = '0;
        cpu_state.sp  = SP_RESET;
        cpu_state.i   = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_binary_arith();
        test_decimal_arith();
        test_status_load();
        test_bit_ops();
        test_compare_shift();
        test_backpressure();
        test_random();

        u_in.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("cpu_register_alu_execute verification clean");
        end else begin
            $display("cpu_register_alu_execute verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/cra_pkg.sv
design/cra_intf.sv
design/cra_alu.sv
design/cpu_register_alu_execute.sv
dv/cpu_register_alu_execute_test.sv
